// ===== rtl/core/hrma_pkg.sv =====
// Shared constants and types for the humidity risk moving average block.
`default_nettype none

package hrma_pkg;

    localparam int WINDOW_SIZE = 10;
    localparam int SAMPLE_W    = 16;
    localparam int POS_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int SUM_W       = $clog2(WINDOW_SIZE * 65535 + 1);

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd60;

    typedef enum logic [1:0] {
        RISK_NOT_FILLED   = 2'd0,
        RISK_LOW_HUMIDITY = 2'd1,
        RISK_TEMP_FALLING = 2'd2,
        RISK_TEMP_STEADY  = 2'd3
    } risk_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] co2;
        logic [SAMPLE_W-1:0] temperature;
        logic [SAMPLE_W-1:0] humidity;
    } sample_set_t;

endpackage

`default_nettype wire

// ===== rtl/core/hrma_avg_div.sv =====
// Two-step divide of a window sum by the window size: reciprocal multiply, then correction.
`default_nettype none

module hrma_avg_div (
    input  logic                          clk,
    input  logic                          load,
    input  logic [hrma_pkg::SUM_W-1:0]    sum,
    output logic [hrma_pkg::SAMPLE_W-1:0] quotient
);
    import hrma_pkg::*;

    localparam int PROD_W = 2 * SUM_W;
    localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'd1 << SUM_W) / WINDOW_SIZE);
    localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(WINDOW_SIZE);

    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  estimate;
    logic [SUM_W-1:0]  back_product;
    logic [SUM_W-1:0]  remainder;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg  <= sum;
            prod_reg <= PROD_W'(sum) * PROD_W'(RECIP);
        end
    end

    // The estimate is never above the true quotient and at most one below it.
    always_comb
    begin
        estimate     = prod_reg[PROD_W-1:SUM_W];
        back_product = SUM_W'(estimate * DIVISOR);
        remainder    = sum_reg - back_product;
        if (remainder >= DIVISOR)
        begin
            quotient = SAMPLE_W'(estimate + 1'b1);
        end
        else
        begin
            quotient = SAMPLE_W'(estimate);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/humidity_risk_moving_average.sv =====
// Top level: three-channel boxcar moving average with humidity/temperature risk status.
//
// Input channel: in_valid/in_stall carry one beat of CO2, temperature and humidity samples
// plus sample_valid. A beat with sample_valid low leaves windows and sums untouched but
// still advances the write position and still yields a result.
// Output channel: out_valid/out_stall carry one result beat per input beat, in order:
// three truncated averages and risk_status.
// Configuration: cfg_we/cfg_wdata write the low-humidity limit.
// Pipeline: a beat's ring slot is read as the beat is accepted, the sum update and
// reciprocal multiply happen as stage 1 advances, and the correction goes into the output
// register as stage 2 advances. Throughput: one beat per cycle while out_stall stays low,
// set by the ring memory's single read and single write per cycle and the per-channel
// sum read-modify-write.
// Reset: position, filled flag, sums and threshold go to their reset values at once;
// the ring entries are masked to zero by per-slot written flags, so no clearing pass.
// Stall: a held out_stall freezes the output register, then the pipeline stages behind
// it, and in_stall rises once the first stage can no longer drain.
`default_nettype none

module humidity_risk_moving_average (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hrma_pkg::SAMPLE_W-1:0] co2_sample,
    input  logic [hrma_pkg::SAMPLE_W-1:0] temperature_sample,
    input  logic [hrma_pkg::SAMPLE_W-1:0] humidity_sample,
    input  logic                          sample_valid,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hrma_pkg::SAMPLE_W-1:0] co2_average,
    output logic [hrma_pkg::SAMPLE_W-1:0] temperature_average,
    output logic [hrma_pkg::SAMPLE_W-1:0] humidity_average,
    output hrma_pkg::risk_t               risk_status,
    input  logic                          cfg_we,
    input  logic [hrma_pkg::SAMPLE_W-1:0] cfg_wdata
);
    import hrma_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_SIZE - 1);

    // write position and fill state
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                filled_reg, filled_next;
    logic                wrap;
    logic                accept;

    // ring memory
    sample_set_t         ring_mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] slot_written_reg;
    sample_set_t         rd_data_reg;
    logic                rd_hit_reg;
    sample_set_t         old_set;

    // stage 1: read returned, sums updated on advance
    logic                s1_valid_reg;
    logic [POS_W-1:0]    s1_slot_reg;
    sample_set_t         s1_samples_reg;
    logic                s1_sample_valid_reg;
    logic                s1_filled_reg;
    logic                adv2;

    logic [SUM_W-1:0]    co2_sum_reg, co2_sum_next;
    logic [SUM_W-1:0]    temp_sum_reg, temp_sum_next;
    logic [SUM_W-1:0]    hum_sum_reg, hum_sum_next;

    // stage 2: products held in the dividers
    logic                s2_valid_reg;
    logic [SAMPLE_W-1:0] s2_temp_reg;
    logic                s2_filled_reg;
    logic                adv3;
    logic [SAMPLE_W-1:0] co2_quot, temp_quot, hum_quot;
    risk_t               status;

    // output register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] co2_avg_reg, temp_avg_reg, hum_avg_reg;
    risk_t               status_reg;

    logic [SAMPLE_W-1:0] threshold_reg;

    // handshake and stage advance
    assign adv3     = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign adv2     = s1_valid_reg && (!s2_valid_reg || adv3);
    assign in_stall = s1_valid_reg && !adv2;
    assign accept   = in_valid && !in_stall;

    assign wrap        = (pos_reg == LAST_POS);
    assign pos_next    = wrap ? '0 : pos_reg + 1'b1;
    assign filled_next = filled_reg | wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            if (accept)
            begin
                pos_reg    <= pos_next;
                filled_reg <= filled_next;
            end
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
        end
    end

    // Read the slot as the beat enters; write it back when stage 1 advances with a valid sample.
    // Adjacent beats always hit different slots, so no read can meet a pending write.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= ring_mem[pos_reg];
            rd_hit_reg  <= slot_written_reg[pos_reg];
        end
        if (adv2 && s1_sample_valid_reg)
        begin
            ring_mem[s1_slot_reg] <= s1_samples_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_written_reg <= '0;
        end
        else if (adv2 && s1_sample_valid_reg)
        begin
            slot_written_reg[s1_slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv2)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg                <= pos_reg;
            s1_samples_reg.co2         <= co2_sample;
            s1_samples_reg.temperature <= temperature_sample;
            s1_samples_reg.humidity    <= humidity_sample;
            s1_sample_valid_reg        <= sample_valid;
            s1_filled_reg              <= filled_next;
        end
    end

    // Slots never written read as zero.
    assign old_set = rd_hit_reg ? rd_data_reg : '0;

    always_comb
    begin
        co2_sum_next  = co2_sum_reg;
        temp_sum_next = temp_sum_reg;
        hum_sum_next  = hum_sum_reg;
        if (s1_sample_valid_reg)
        begin
            co2_sum_next  = co2_sum_reg - SUM_W'(old_set.co2)
                            + SUM_W'(s1_samples_reg.co2);
            temp_sum_next = temp_sum_reg - SUM_W'(old_set.temperature)
                            + SUM_W'(s1_samples_reg.temperature);
            hum_sum_next  = hum_sum_reg - SUM_W'(old_set.humidity)
                            + SUM_W'(s1_samples_reg.humidity);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            co2_sum_reg  <= '0;
            temp_sum_reg <= '0;
            hum_sum_reg  <= '0;
        end
        else if (adv2)
        begin
            co2_sum_reg  <= co2_sum_next;
            temp_sum_reg <= temp_sum_next;
            hum_sum_reg  <= hum_sum_next;
        end
    end

    hrma_avg_div u_co2_div (
        .clk      (clk),
        .load     (adv2),
        .sum      (co2_sum_next),
        .quotient (co2_quot)
    );

    hrma_avg_div u_temp_div (
        .clk      (clk),
        .load     (adv2),
        .sum      (temp_sum_next),
        .quotient (temp_quot)
    );

    hrma_avg_div u_hum_div (
        .clk      (clk),
        .load     (adv2),
        .sum      (hum_sum_next),
        .quotient (hum_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (adv3)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_temp_reg   <= s1_samples_reg.temperature;
            s2_filled_reg <= s1_filled_reg;
        end
    end

    always_comb
    begin
        priority if (!s2_filled_reg)
        begin
            status = RISK_NOT_FILLED;
        end
        else if (hum_quot < threshold_reg)
        begin
            status = RISK_LOW_HUMIDITY;
        end
        else if (s2_temp_reg < temp_quot)
        begin
            status = RISK_TEMP_FALLING;
        end
        else
        begin
            status = RISK_TEMP_STEADY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv3)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            co2_avg_reg  <= co2_quot;
            temp_avg_reg <= temp_quot;
            hum_avg_reg  <= hum_quot;
            status_reg   <= status;
        end
    end

    assign out_valid           = out_valid_reg;
    assign co2_average         = co2_avg_reg;
    assign temperature_average = temp_avg_reg;
    assign humidity_average    = hum_avg_reg;
    assign risk_status         = status_reg;

    // checks
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < WINDOW_SIZE)
        else $error("write position beyond window");

    a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg |=> filled_reg)
        else $error("filled flag dropped");

    a_wrap_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && wrap) |=> (filled_reg && s1_filled_reg))
        else $error("wrapping beat did not see the window filled");

    a_accept_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (s1_valid_reg && s1_slot_reg == $past(pos_reg)))
        else $error("accepted beat missing from first stage");

endmodule

`default_nettype wire

// ===== sim/humidity_risk_moving_average_test.sv =====
// Self-checking testbench for the humidity risk moving average block.
`timescale 1ns / 1ps

module humidity_risk_moving_average_test;

    import hrma_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [SAMPLE_W-1:0] co2;
        logic [SAMPLE_W-1:0] temperature;
        logic [SAMPLE_W-1:0] humidity;
        risk_t               risk;
    } average_set_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] co2_sample = '0;
    logic [SAMPLE_W-1:0] temperature_sample = '0;
    logic [SAMPLE_W-1:0] humidity_sample = '0;
    logic                sample_valid = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SAMPLE_W-1:0] co2_average;
    logic [SAMPLE_W-1:0] temperature_average;
    logic [SAMPLE_W-1:0] humidity_average;
    risk_t               risk_status;
    logic                cfg_we = 1'b0;
    logic [SAMPLE_W-1:0] cfg_wdata = '0;

    // Window model: ring slots, running sums, position, filled flag, threshold
    logic [SAMPLE_W-1:0] co2_ring [WINDOW_SIZE] = '{default: '0};
    logic [SAMPLE_W-1:0] temp_ring [WINDOW_SIZE] = '{default: '0};
    logic [SAMPLE_W-1:0] hum_ring [WINDOW_SIZE] = '{default: '0};
    logic [31:0]         co2_sum = '0;
    logic [31:0]         temp_sum = '0;
    logic [31:0]         hum_sum = '0;
    int                  ring_pos = 0;
    logic                ring_filled = 1'b0;
    logic [SAMPLE_W-1:0] threshold_model = THRESHOLD_RESET;

    average_set_t pending_averages[$];
    average_set_t observed;
    average_set_t wanted;
    int           error_count = 0;
    int           cycle_count = 0;

    logic src_gaps_on = 1'b1;
    logic sink_gaps_on = 1'b1;
    int   hold_seq = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    humidity_risk_moving_average u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .co2_sample          (co2_sample),
        .temperature_sample  (temperature_sample),
        .humidity_sample     (humidity_sample),
        .sample_valid        (sample_valid),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .co2_average         (co2_average),
        .temperature_average (temperature_average),
        .humidity_average    (humidity_average),
        .risk_status         (risk_status),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("humidity_risk_moving_average_test NOT OK");
            $finish;
        end
    end

    // Receiver: long hold-off on request, else random stalls
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (sink_gaps_on && $urandom_range(0, 99) < 20)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed = '{co2_average, temperature_average, humidity_average, risk_status};
            if (pending_averages.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected result beat: co2 %0d temp %0d hum %0d risk %s",
                             observed.co2, observed.temperature, observed.humidity,
                             observed.risk.name());
            end
            else
            begin
                wanted = pending_averages.pop_front();
                if (observed.co2 !== wanted.co2
                    || observed.temperature !== wanted.temperature
                    || observed.humidity !== wanted.humidity
                    || observed.risk !== wanted.risk)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("mismatch: expected %0d/%0d/%0d/%s got %0d/%0d/%0d/%s",
                                 wanted.co2, wanted.temperature, wanted.humidity,
                                 wanted.risk.name(), observed.co2, observed.temperature,
                                 observed.humidity, observed.risk.name());
                end
            end
        end
    end

    function automatic average_set_t next_averages(input logic [SAMPLE_W-1:0] co2,
                                                   input logic [SAMPLE_W-1:0] temp,
                                                   input logic [SAMPLE_W-1:0] hum,
                                                   input logic valid);
        average_set_t result;
        if (valid)
        begin
            co2_sum  = co2_sum - co2_ring[ring_pos] + co2;
            temp_sum = temp_sum - temp_ring[ring_pos] + temp;
            hum_sum  = hum_sum - hum_ring[ring_pos] + hum;
            co2_ring[ring_pos]  = co2;
            temp_ring[ring_pos] = temp;
            hum_ring[ring_pos]  = hum;
        end
        // Advance before judging: the wrapping beat already counts as filled
        ring_pos++;
        if (ring_pos >= WINDOW_SIZE)
        begin
            ring_pos = 0;
            ring_filled = 1'b1;
        end
        result.co2         = 16'(co2_sum / WINDOW_SIZE);
        result.temperature = 16'(temp_sum / WINDOW_SIZE);
        result.humidity    = 16'(hum_sum / WINDOW_SIZE);
        if (!ring_filled)
            result.risk = RISK_NOT_FILLED;
        else if (result.humidity < threshold_model)
            result.risk = RISK_LOW_HUMIDITY;
        else if (temp < result.temperature)
            result.risk = RISK_TEMP_FALLING;
        else
            result.risk = RISK_TEMP_STEADY;
        return result;
    endfunction

    // Called just after a rising edge; returns at the edge that takes the beat
    task automatic send_sample(input logic [SAMPLE_W-1:0] co2,
                               input logic [SAMPLE_W-1:0] temp,
                               input logic [SAMPLE_W-1:0] hum,
                               input logic valid);
        if (src_gaps_on)
        begin
            while ($urandom_range(0, 99) < 20)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid           <= 1'b1;
        co2_sample         <= co2;
        temperature_sample <= temp;
        humidity_sample    <= hum;
        sample_valid       <= valid;
        do
            @(posedge clk);
        while (in_stall);
        pending_averages.push_back(next_averages(co2, temp, hum, valid));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_averages.size() != 0);
    endtask

    task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold_model = value;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int base);
        int roll;
        int value;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 16'h0000;
        if (roll < 16)
            return 16'hFFFF;
        if (roll < 40)
            return 16'($urandom);
        // Stay near the base so the trend test lands close to the average
        value = base + int'($urandom_range(0, 80)) - 40;
        if (value < 0)
            value = 0;
        if (value > 65535)
            value = 65535;
        return value[SAMPLE_W-1:0];
    endfunction

    task automatic test_directed_fill_and_trend();
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
        send_sample(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
        // Invalid beat: sums hold, position still moves
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        // Fill the rest, then make the whole window 1000 on every channel
        repeat (15)
            send_sample(16'd1000, 16'd1000, 16'd1000, 1'b1);
        // Temperature equal to the average, then below, then above, on invalid beats
        send_sample(16'hFFFF, 16'd1000, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'd999, 16'hFFFF, 1'b0);
        send_sample(16'h0000, 16'd1001, 16'h0000, 1'b0);
        wait_for_results();
    endtask

    task automatic test_threshold_extremes();
        write_threshold(16'hFFFF);
        repeat (12)
            send_sample(pick_sample(1000), pick_sample(1000), pick_sample(1000), 1'b1);
        write_threshold(16'h0000);
        repeat (12)
            send_sample(pick_sample(1000), pick_sample(1000), pick_sample(1000), 1'b1);
        write_threshold(16'(hum_sum / WINDOW_SIZE));
        repeat (12)
            send_sample(pick_sample(1000), pick_sample(1000), pick_sample(1000),
                        $urandom_range(0, 3) != 0);
        write_threshold(THRESHOLD_RESET);
    endtask

    task automatic test_backpressure();
        src_gaps_on = 1'b0;
        hold_seq <= hold_seq + 1;
        repeat (30)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(0, 5) != 0);
        wait_for_results();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int co2_base;
        int temp_base;
        int hum_base;
        for (int phase = 0; phase < 6; phase++)
        begin
            co2_base  = $urandom_range(0, 65535);
            temp_base = $urandom_range(0, 65535);
            hum_base  = $urandom_range(0, 65535);
            case (phase % 4)
                0: write_threshold(16'($urandom));
                1: write_threshold(16'(hum_base));
                2: write_threshold(16'h0000);
                default: write_threshold(16'hFFFF);
            endcase
            // One phase runs with no idling on either side
            src_gaps_on  = (phase != 3);
            sink_gaps_on = (phase != 3);
            repeat (100)
                send_sample(pick_sample(co2_base), pick_sample(temp_base),
                            pick_sample(hum_base), $urandom_range(0, 99) < 85);
        end
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        wait_for_results();
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed_fill_and_trend();
        test_threshold_extremes();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (8)
            @(posedge clk);
        if (error_count == 0 && pending_averages.size() == 0)
            $display("humidity_risk_moving_average_test OK");
        else
            $display("humidity_risk_moving_average_test NOT OK");
        $finish;
    end

endmodule
